>>> rtl/lcc_pkg.sv
package lcc_pkg;

   // echo capture timer period in ticks
   localparam int unsigned CAPTURE_PERIOD = 40000;
   localparam logic [15:0] CAPTURE_PERIOD_W = 16'(CAPTURE_PERIOD);

   // full scale of the potentiometer converter, 2**POT_BITS - 1
   localparam int unsigned POT_BITS = 10;
   localparam logic [POT_BITS-1:0] POT_FULL = '1;

   localparam int unsigned REG_ADDR_BITS = 5;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_SAFE   = 2'd2,
      MODE_EMERG  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      BMSG_NONE          = 2'd0,
      BMSG_EMERG_ON      = 2'd1,
      BMSG_EMERG_RESET   = 2'd2,
      BMSG_RESET_BLOCKED = 2'd3
   } bmsg_type;

   typedef enum logic [2:0] {
      CMSG_NONE          = 3'd0,
      CMSG_RESET         = 3'd1,
      CMSG_RESET_BLOCKED = 3'd2,
      CMSG_CLOSE         = 3'd3,
      CMSG_OPEN          = 3'd4,
      CMSG_OPEN_BLOCKED  = 3'd5,
      CMSG_EMERG         = 3'd6
   } cmsg_type;

   typedef enum logic [2:0] {
      REG_ECHO_LOW   = 3'd0,
      REG_ECHO_HIGH  = 3'd1,
      REG_DELAY_BASE = 3'd2,
      REG_DELAY_SPAN = 3'd3,
      REG_DEBOUNCE   = 3'd4,
      REG_FLASH      = 3'd5,
      REG_TRIGGER    = 3'd6
   } reg_index_type;

   // command letters
   localparam logic [7:0] CHAR_R_UP = 8'h52;
   localparam logic [7:0] CHAR_R_LO = 8'h72;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_O_UP = 8'h4F;
   localparam logic [7:0] CHAR_O_LO = 8'h6F;
   localparam logic [7:0] CHAR_E_UP = 8'h45;
   localparam logic [7:0] CHAR_E_LO = 8'h65;

   typedef struct packed {
      logic                capture_valid;
      logic [15:0]         capture_time;
      logic [POT_BITS-1:0] pot_sample;
      logic                button_fall;
      logic                rx_valid;
      logic [7:0]          rx_byte;
   } req_item_type;

   // packed so that the first field sits in the highest bits
   typedef struct packed {
      cmsg_type command_message;
      bmsg_type button_message;
      logic     trigger_pulse;
      logic     red_on;
      logic     green_on;
      logic     buzzer_on;
      logic     gate_closed;
      mode_type crossing_state;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] echo_low_ticks;
      logic [15:0] echo_high_ticks;
      logic [15:0] delay_base_ms;
      logic [15:0] delay_span_ms;
      logic [15:0] debounce_ms;
      logic [15:0] flash_ms;
      logic [15:0] trigger_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      echo_low_ticks:  16'd232,
      echo_high_ticks: 16'd2320,
      delay_base_ms:   16'd1000,
      delay_span_ms:   16'd5000,
      debounce_ms:     16'd300,
      flash_ms:        16'd500,
      trigger_ms:      16'd200
   };

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == '1) ? v : v + 16'd1;
   endfunction

endpackage

>>> rtl/lcc_delay_pipe.sv
module lcc_delay_pipe
   import lcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   input  logic [15:0]  delay_base_ms,
   input  logic [15:0]  delay_span_ms,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item,
   output logic [15:0]  out_delay
);

   localparam int unsigned PROD_BITS = POT_BITS + 16;

   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;

   req_item_type item1_ff, item2_ff, item3_ff;
   logic [PROD_BITS-1:0] prod1_ff, prod2_ff;
   logic [15:0] quot2_ff;
   logic [15:0] delay3_ff;

   logic [PROD_BITS:0]   approx_sum;
   logic [PROD_BITS-1:0] remainder;
   logic                 round_up;
   logic [16:0]          delay_sum;

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // x / (2**10 - 1) ~ (x + x>>10 + x>>20) >> 10, never above the true quotient
   assign approx_sum = {1'b0, prod1_ff}
                     + {1'b0, (prod1_ff >> POT_BITS)}
                     + {1'b0, (prod1_ff >> (2 * POT_BITS))};

   // remainder is below twice the divisor, so one step corrects
   assign remainder = prod2_ff - {quot2_ff, {POT_BITS{1'b0}}}
                    + {{(PROD_BITS-16){1'b0}}, quot2_ff};
   assign round_up  = remainder >= {{(PROD_BITS-POT_BITS){1'b0}}, POT_FULL};
   assign delay_sum = {1'b0, delay_base_ms} + {1'b0, quot2_ff} + {16'd0, round_up};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         item1_ff <= in_item;
         prod1_ff <= {{(PROD_BITS-POT_BITS){1'b0}}, in_item.pot_sample}
                   * {{(PROD_BITS-16){1'b0}}, delay_span_ms};
      end
      if (ready2 && v1_ff) begin
         item2_ff <= item1_ff;
         prod2_ff <= prod1_ff;
         quot2_ff <= approx_sum[PROD_BITS-1:POT_BITS];
      end
      if (ready3 && v2_ff) begin
         item3_ff  <= item2_ff;
         delay3_ff <= delay_sum[16] ? 16'hFFFF : delay_sum[15:0];
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;
   assign out_delay = delay3_ff;

endmodule

>>> rtl/level_crossing_controller_top.sv
// level crossing controller, one request per millisecond tick
// accepted requests pass the delay pipeline stages, then the output register
// throughput: one request per cycle unless rsp_tready stalls; the crossing
//   state updates in the cycle the last stage loads the output register
// reset: synchronous, active high; registers that have a reset return to
//   their reset values, no clearing pass; a request can be taken after reset
module level_crossing_controller_top
   import lcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   // request: tdata = capture_time[15:0], pot_sample[25:16], button_fall[26],
   //   rx_byte[34:27], zero pad [39:35]
   //   tuser = capture_valid[0], rx_valid[1]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [39:0]              req_tdata,
   input  logic [1:0]               req_tuser,

   // response: tdata = crossing_state[1:0], gate_closed[2], buzzer_on[3],
   //   green_on[4], red_on[5], trigger_pulse[6], button_message[8:7],
   //   command_message[11:9], zero pad [15:12]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,

   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [REG_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   // ---------------------------------------------------------------------
   // register file
   // ---------------------------------------------------------------------
   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[REG_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_ECHO_LOW:   cfg_ff.echo_low_ticks  <= csr_pwdata[15:0];
            REG_ECHO_HIGH:  cfg_ff.echo_high_ticks <= csr_pwdata[15:0];
            REG_DELAY_BASE: cfg_ff.delay_base_ms   <= csr_pwdata[15:0];
            REG_DELAY_SPAN: cfg_ff.delay_span_ms   <= csr_pwdata[15:0];
            REG_DEBOUNCE:   cfg_ff.debounce_ms     <= csr_pwdata[15:0];
            REG_FLASH:      cfg_ff.flash_ms        <= csr_pwdata[15:0];
            REG_TRIGGER:    cfg_ff.trigger_ms      <= csr_pwdata[15:0];
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ECHO_LOW:   csr_prdata = {16'd0, cfg_ff.echo_low_ticks};
         REG_ECHO_HIGH:  csr_prdata = {16'd0, cfg_ff.echo_high_ticks};
         REG_DELAY_BASE: csr_prdata = {16'd0, cfg_ff.delay_base_ms};
         REG_DELAY_SPAN: csr_prdata = {16'd0, cfg_ff.delay_span_ms};
         REG_DEBOUNCE:   csr_prdata = {16'd0, cfg_ff.debounce_ms};
         REG_FLASH:      csr_prdata = {16'd0, cfg_ff.flash_ms};
         REG_TRIGGER:    csr_prdata = {16'd0, cfg_ff.trigger_ms};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // request unpacking and safety delay pipeline
   // the delay depends only on the request and the registers, so it is
   // worked out ahead of the state update in three short stages
   // ---------------------------------------------------------------------
   req_item_type req_item;
   req_item_type step_item;
   logic         step_valid;
   logic         step_ready;
   logic [15:0]  step_delay;

   assign req_item = '{capture_valid: req_tuser[0],
                       capture_time:  req_tdata[15:0],
                       pot_sample:    req_tdata[25:16],
                       button_fall:   req_tdata[26],
                       rx_valid:      req_tuser[1],
                       rx_byte:       req_tdata[34:27]};

   lcc_delay_pipe u_delay_pipe (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_item       (req_item),
      .delay_base_ms (cfg_ff.delay_base_ms),
      .delay_span_ms (cfg_ff.delay_span_ms),
      .out_valid     (step_valid),
      .out_ready     (step_ready),
      .out_item      (step_item),
      .out_delay     (step_delay)
   );

   // ---------------------------------------------------------------------
   // crossing state
   // ---------------------------------------------------------------------
   mode_type    mode_ff, mode_in;
   logic        emerg_ff, emerg_in;
   logic        train_ff, train_in;
   logic        awaiting_ff, awaiting_in;
   logic [15:0] rise_ff, rise_in;
   logic [15:0] since_train_ff, since_train_in;
   logic [15:0] since_press_ff, since_press_in;
   logic [15:0] since_flash_ff, since_flash_in;
   logic [15:0] since_trig_ff, since_trig_in;
   logic        phase_ff, phase_in;
   logic        red_ff, red_in;

   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff;
   logic         step_fire;
   logic [15:0]  echo_width;

   // output register frees up when empty or being taken
   assign step_ready = !rsp_valid_ff || rsp_tready;
   assign step_fire  = step_valid && step_ready;

   // pulse width, wrapping at the capture period
   assign echo_width = (step_item.capture_time >= rise_ff)
                     ? step_item.capture_time - rise_ff
                     : CAPTURE_PERIOD_W - rise_ff + step_item.capture_time;

   always_comb begin
      mode_in        = mode_ff;
      emerg_in       = emerg_ff;
      train_in       = train_ff;
      awaiting_in    = awaiting_ff;
      rise_in        = rise_ff;
      phase_in       = phase_ff;
      red_in         = red_ff;
      since_train_in = sat_inc(since_train_ff);
      since_press_in = sat_inc(since_press_ff);
      since_flash_in = sat_inc(since_flash_ff);
      since_trig_in  = sat_inc(since_trig_ff);
      rsp_in         = '{crossing_state:  MODE_IDLE,
                         gate_closed:     1'b0,
                         buzzer_on:       1'b0,
                         green_on:        1'b1,
                         red_on:          1'b0,
                         trigger_pulse:   1'b0,
                         button_message:  BMSG_NONE,
                         command_message: CMSG_NONE};

      // ultrasonic trigger strobe
      if (since_trig_in >= cfg_ff.trigger_ms) begin
         since_trig_in        = '0;
         rsp_in.trigger_pulse = 1'b1;
      end

      // echo edge pairing and train detection
      if (step_item.capture_valid) begin
         if (!awaiting_ff) begin
            rise_in     = step_item.capture_time;
            awaiting_in = 1'b1;
         end else begin
            awaiting_in = 1'b0;
            train_in    = (echo_width > cfg_ff.echo_low_ticks)
                       && (echo_width < cfg_ff.echo_high_ticks);
         end
      end

      // debounced emergency button
      if (step_item.button_fall && (since_press_in > cfg_ff.debounce_ms)) begin
         since_press_in = '0;
         if (!emerg_ff) begin
            emerg_in              = 1'b1;
            mode_in               = MODE_EMERG;
            rsp_in.button_message = BMSG_EMERG_ON;
         end else if (!train_in) begin
            emerg_in              = 1'b0;
            mode_in               = MODE_IDLE;
            rsp_in.button_message = BMSG_EMERG_RESET;
         end else begin
            rsp_in.button_message = BMSG_RESET_BLOCKED;
         end
      end

      // crossing sequence
      unique case (mode_in)
         MODE_IDLE: begin
            if (emerg_in) begin
               mode_in = MODE_EMERG;
            end else if (train_in) begin
               mode_in        = MODE_ACTIVE;
               since_train_in = '0;
            end
         end
         MODE_ACTIVE: begin
            if (emerg_in) begin
               mode_in = MODE_EMERG;
            end else if (train_in) begin
               since_train_in = '0;
            end else if (since_train_in >= step_delay) begin
               mode_in = MODE_SAFE;
            end
         end
         MODE_SAFE: begin
            mode_in = MODE_IDLE;
         end
         MODE_EMERG: begin
            if (!emerg_in && !train_in) begin
               mode_in = MODE_IDLE;
            end
         end
      endcase

      // gate, buzzer and lamps follow the state before the serial command
      if (mode_in == MODE_IDLE || mode_in == MODE_SAFE) begin
         red_in = 1'b0;
      end else begin
         rsp_in.gate_closed = 1'b1;
         rsp_in.buzzer_on   = 1'b1;
         rsp_in.green_on    = 1'b0;
         if (mode_in == MODE_ACTIVE) begin
            // red holds its level between toggles
            if (since_flash_in >= cfg_ff.flash_ms) begin
               since_flash_in = '0;
               phase_in       = !phase_ff;
               red_in         = !phase_ff;
            end
         end else begin
            red_in = 1'b1;
         end
      end
      rsp_in.red_on = red_in;

      // serial letter command, upper or lower case; other bytes ignored
      if (step_item.rx_valid) begin
         unique case (step_item.rx_byte) inside
            CHAR_R_UP, CHAR_R_LO: begin
               if (!train_in) begin
                  emerg_in               = 1'b0;
                  mode_in                = MODE_IDLE;
                  rsp_in.command_message = CMSG_RESET;
               end else begin
                  rsp_in.command_message = CMSG_RESET_BLOCKED;
               end
            end
            CHAR_C_UP, CHAR_C_LO: begin
               mode_in                = MODE_ACTIVE;
               since_train_in         = '0;
               rsp_in.command_message = CMSG_CLOSE;
            end
            CHAR_O_UP, CHAR_O_LO: begin
               if (!train_in && !emerg_in) begin
                  mode_in                = MODE_SAFE;
                  rsp_in.command_message = CMSG_OPEN;
               end else begin
                  rsp_in.command_message = CMSG_OPEN_BLOCKED;
               end
            end
            CHAR_E_UP, CHAR_E_LO: begin
               emerg_in               = 1'b1;
               mode_in                = MODE_EMERG;
               rsp_in.command_message = CMSG_EMERG;
            end
            default: ;
         endcase
      end

      rsp_in.crossing_state = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         emerg_ff       <= 1'b0;
         train_ff       <= 1'b0;
         awaiting_ff    <= 1'b0;
         rise_ff        <= '0;
         since_train_ff <= '0;
         since_press_ff <= '0;
         since_flash_ff <= '0;
         since_trig_ff  <= '0;
         phase_ff       <= 1'b0;
         red_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (step_fire) begin
            mode_ff        <= mode_in;
            emerg_ff       <= emerg_in;
            train_ff       <= train_in;
            awaiting_ff    <= awaiting_in;
            rise_ff        <= rise_in;
            since_train_ff <= since_train_in;
            since_press_ff <= since_press_in;
            since_flash_ff <= since_flash_in;
            since_trig_ff  <= since_trig_in;
            phase_ff       <= phase_in;
            red_ff         <= red_in;
         end
         if (step_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff};

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // gate down and green lamp are always opposite
   a_gate_green: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.gate_closed != rsp_ff.green_on))
      else $error("gate and green lamp disagree");

   // an emergency command always leaves the crossing in emergency
   a_cmd_emerg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.command_message == CMSG_EMERG)
      |-> (rsp_ff.crossing_state == MODE_EMERG))
      else $error("emergency command without emergency state");

   // without a command, emergency shows a steady red
   a_emerg_red: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.command_message == CMSG_NONE
       && rsp_ff.crossing_state == MODE_EMERG) |-> rsp_ff.red_on)
      else $error("red lamp off in emergency");

   // emergency state is only held with the emergency flag set
   a_emerg_flag: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_EMERG) |-> emerg_ff)
      else $error("emergency state without emergency flag");

endmodule
